@@ design/ple_pkg.sv @@
// Shared definitions for the positional list engine.
// Field widths, operation codes and status codes; no dependencies.
`default_nettype none

package ple_pkg;

    localparam int unsigned POS_W  = 6;
    localparam int unsigned VAL_W  = 31;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned OP_W   = 2;

    localparam int unsigned DEPTH_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_RANGE     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

endpackage

`default_nettype wire

@@ design/positional_list_engine_top.sv @@
// Positional list engine: top level with the control sequencer and result register.
// Depends on ple_pkg and ple_ram.
`default_nettype none

// Ordered list of up to DEPTH 31-bit values held in one synchronous RAM,
// plus an entry count. One request is processed at a time; req_stall is low
// only while the engine is idle. Insert walks the entries from the end of the
// list down to the target position, moving each one up by one slot (one RAM
// read and one RAM write per cycle), then writes the new value. Remove walks
// up from the position moving each entry down. Read registers the RAM data as
// its result. Search streams every live entry through the read port, one per
// cycle unless a second match waits on a stalled response register, and
// compares it against the key. The single RAM port pair paces every walk. A
// search emits one response per matching position in rising order; one match
// is held back so that the final response can carry last. Errors (full,
// empty, position out of range, not found) give a single response with zero
// position and value. The result sits in an output register, so the next
// request is taken while that response waits. No clearing pass after reset:
// only entries below the count are ever read.
module positional_list_engine_top #(
    parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request channel
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [ple_pkg::OP_W-1:0]    op,
    input  wire logic [ple_pkg::POS_W-1:0]   position,
    input  wire logic [ple_pkg::VAL_W-1:0]   value,
    // response channel
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic [ple_pkg::STAT_W-1:0]       status,
    output logic [ple_pkg::POS_W-1:0]        found_position,
    output logic [ple_pkg::VAL_W-1:0]        read_value,
    output logic [ple_pkg::CNT_W-1:0]        entry_count,
    output logic                             last
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNT_W = ple_pkg::CNT_W;
    localparam int unsigned POS_W = ple_pkg::POS_W;
    localparam int unsigned VAL_W = ple_pkg::VAL_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_REM,
        ST_RD,
        ST_SRCH,
        ST_RESP
    } state_t;

    // sequencer state
    state_t                    state_reg,  state_next;
    logic [CNT_W-1:0]          count_reg,  count_next;
    logic [CNT_W-1:0]          idx_reg,    idx_next;
    logic [POS_W-1:0]          pos_reg,    pos_next;
    logic [VAL_W-1:0]          val_reg,    val_next;

    // write-back stage of the shift walk
    logic                      wb_valid_reg, wb_valid_next;
    logic [CNT_W-1:0]          wb_addr_reg,  wb_addr_next;

    // search read pipeline and held match
    logic                      p_valid_reg,  p_valid_next;
    logic [POS_W-1:0]          p_idx_reg,    p_idx_next;
    logic                      hold_valid_reg, hold_valid_next;
    logic [POS_W-1:0]          hold_pos_reg,   hold_pos_next;
    logic [VAL_W-1:0]          hold_val_reg,   hold_val_next;

    // pending single response
    ple_pkg::status_t          res_status_reg, res_status_next;
    logic [POS_W-1:0]          res_pos_reg,    res_pos_next;
    logic [VAL_W-1:0]          res_val_reg,    res_val_next;

    // response register
    logic                      rsp_valid_reg,  rsp_valid_next;
    logic [ple_pkg::STAT_W-1:0] rsp_status_reg, rsp_status_next;
    logic [POS_W-1:0]          rsp_pos_reg,    rsp_pos_next;
    logic [VAL_W-1:0]          rsp_val_reg,    rsp_val_next;
    logic [CNT_W-1:0]          rsp_count_reg,  rsp_count_next;
    logic                      rsp_last_reg,   rsp_last_next;

    // RAM port
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [VAL_W-1:0]          mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic [VAL_W-1:0]          mem_rdata;

    logic                      out_free;
    logic [CNT_W-1:0]          pos_in_ext;
    logic [CNT_W-1:0]          pos_reg_ext;
    logic [CNT_W-1:0]          idx_m1;
    logic [CNT_W-1:0]          idx_p1;
    logic                      match;
    logic                      blocked;
    ple_pkg::op_t              op_in;

    ple_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign pos_in_ext  = CNT_W'(position);
    assign pos_reg_ext = CNT_W'(pos_reg);
    assign idx_m1      = idx_reg - ONE_CNT;
    assign idx_p1      = idx_reg + ONE_CNT;
    assign op_in       = ple_pkg::op_t'(op);
    assign match       = p_valid_reg && (mem_rdata == val_reg);
    // a second match needs the response register to flush the held one
    assign blocked     = match && hold_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        wb_valid_next   = wb_valid_reg;
        wb_addr_next    = wb_addr_reg;
        p_valid_next    = p_valid_reg;
        p_idx_next      = p_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_pos_next   = hold_pos_reg;
        hold_val_next   = hold_val_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_val_next    = res_val_reg;

        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_val_next    = rsp_val_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_last_next   = rsp_last_reg;

        mem_we          = 1'b0;
        mem_waddr       = wb_addr_reg[AW-1:0];
        mem_wdata       = mem_rdata;
        mem_raddr       = position[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next      = position;
                    val_next      = value;
                    wb_valid_next = 1'b0;
                    res_pos_next  = '0;
                    res_val_next  = '0;
                    state_next    = ST_RESP;
                    if (op_in == ple_pkg::OP_INSERT)
                    begin
                        if (count_reg == DEPTH_CNT)
                        begin
                            res_status_next = ple_pkg::STAT_FULL;
                        end
                        else if (pos_in_ext > count_reg)
                        begin
                            res_status_next = ple_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = ST_INS;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ple_pkg::STAT_EMPTY;
                    end
                    else if (op_in == ple_pkg::OP_SEARCH)
                    begin
                        idx_next        = '0;
                        p_valid_next    = 1'b0;
                        hold_valid_next = 1'b0;
                        state_next      = ST_SRCH;
                    end
                    else if (pos_in_ext >= count_reg)
                    begin
                        res_status_next = ple_pkg::STAT_RANGE;
                    end
                    else if (op_in == ple_pkg::OP_READ)
                    begin
                        // RAM read of position is already under way
                        state_next = ST_RD;
                    end
                    else
                    begin
                        idx_next   = pos_in_ext;
                        state_next = ST_REM;
                    end
                end
            end

            ST_INS:
            begin
                if (wb_valid_reg)
                begin
                    mem_we = 1'b1;
                end
                if (idx_reg > pos_reg_ext)
                begin
                    mem_raddr     = idx_m1[AW-1:0];
                    wb_valid_next = 1'b1;
                    wb_addr_next  = idx_reg;
                    idx_next      = idx_m1;
                end
                else
                begin
                    wb_valid_next = 1'b0;
                    if (!wb_valid_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = pos_reg[AW-1:0];
                        mem_wdata       = val_reg;
                        count_next      = count_reg + ONE_CNT;
                        res_status_next = ple_pkg::STAT_OK;
                        res_pos_next    = pos_reg;
                        state_next      = ST_RESP;
                    end
                end
            end

            ST_REM:
            begin
                if (wb_valid_reg)
                begin
                    mem_we = 1'b1;
                end
                if (idx_p1 < count_reg)
                begin
                    mem_raddr     = idx_p1[AW-1:0];
                    wb_valid_next = 1'b1;
                    wb_addr_next  = idx_reg;
                    idx_next      = idx_p1;
                end
                else
                begin
                    wb_valid_next = 1'b0;
                    if (!wb_valid_reg)
                    begin
                        count_next      = count_reg - ONE_CNT;
                        res_status_next = ple_pkg::STAT_OK;
                        res_pos_next    = pos_reg;
                        state_next      = ST_RESP;
                    end
                end
            end

            ST_RD:
            begin
                res_status_next = ple_pkg::STAT_OK;
                res_pos_next    = pos_reg;
                res_val_next    = mem_rdata;
                state_next      = ST_RESP;
            end

            ST_SRCH:
            begin
                if (blocked)
                begin
                    // re-read the same entry so the data stays put
                    mem_raddr = p_idx_reg[AW-1:0];
                end
                else
                begin
                    mem_raddr = idx_reg[AW-1:0];
                    if (match)
                    begin
                        if (hold_valid_reg)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_status_next = ple_pkg::STAT_OK;
                            rsp_pos_next    = hold_pos_reg;
                            rsp_val_next    = hold_val_reg;
                            rsp_count_next  = count_reg;
                            rsp_last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_pos_next   = p_idx_reg;
                        hold_val_next   = mem_rdata;
                    end
                    if (idx_reg < count_reg)
                    begin
                        p_valid_next = 1'b1;
                        p_idx_next   = idx_reg[POS_W-1:0];
                        idx_next     = idx_p1;
                    end
                    else
                    begin
                        p_valid_next = 1'b0;
                    end
                    if (!p_valid_reg && (idx_reg >= count_reg))
                    begin
                        // scan finished: the held match becomes the final one
                        if (hold_valid_reg)
                        begin
                            res_status_next = ple_pkg::STAT_OK;
                            res_pos_next    = hold_pos_reg;
                            res_val_next    = hold_val_reg;
                        end
                        else
                        begin
                            res_status_next = ple_pkg::STAT_NOT_FOUND;
                            res_pos_next    = '0;
                            res_val_next    = '0;
                        end
                        hold_valid_next = 1'b0;
                        state_next      = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_pos_next    = res_pos_reg;
                    rsp_val_next    = res_val_reg;
                    rsp_count_next  = count_reg;
                    rsp_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            val_reg        <= '0;
            wb_valid_reg   <= 1'b0;
            wb_addr_reg    <= '0;
            p_valid_reg    <= 1'b0;
            p_idx_reg      <= '0;
            hold_valid_reg <= 1'b0;
            hold_pos_reg   <= '0;
            hold_val_reg   <= '0;
            res_status_reg <= ple_pkg::STAT_OK;
            res_pos_reg    <= '0;
            res_val_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= '0;
            rsp_pos_reg    <= '0;
            rsp_val_reg    <= '0;
            rsp_count_reg  <= '0;
            rsp_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            wb_valid_reg   <= wb_valid_next;
            wb_addr_reg    <= wb_addr_next;
            p_valid_reg    <= p_valid_next;
            p_idx_reg      <= p_idx_next;
            hold_valid_reg <= hold_valid_next;
            hold_pos_reg   <= hold_pos_next;
            hold_val_reg   <= hold_val_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            res_val_reg    <= res_val_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_pos_reg    <= rsp_pos_next;
            rsp_val_reg    <= rsp_val_next;
            rsp_count_reg  <= rsp_count_next;
            rsp_last_reg   <= rsp_last_next;
        end
    end

    // one request in flight at a time
    assign req_stall      = (state_reg != ST_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_status_reg;
    assign found_position = rsp_pos_reg;
    assign read_value     = rsp_val_reg;
    assign entry_count    = rsp_count_reg;
    assign last           = rsp_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above list depth");

    a_nonlast_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_last_reg) |-> (rsp_status_reg == ple_pkg::STAT_OK))
        else $error("intermediate response without ok status");

    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg != ple_pkg::STAT_OK))
            |-> (rsp_pos_reg == '0 && rsp_val_reg == '0 && rsp_last_reg))
        else $error("error response with nonzero payload or not last");

    a_idle_no_write : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("RAM write while idle");
`endif

endmodule

`default_nettype wire

@@ design/ple_ram.sv @@
// Single-port-write, single-port-read synchronous RAM for the list entries.
// Registered read data; depends on ple_pkg for defaults.
`default_nettype none

module ple_ram #(
    parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF,
    parameter int unsigned WIDTH = ple_pkg::VAL_W,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sim/positional_list_engine_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine_top: random and directed list requests.
// Depends on ple_pkg and the engine RTL; a shadow copy of the list predicts every response.

module positional_list_engine_top_tb;

    import ple_pkg::*;

    localparam int unsigned      DEPTH   = DEPTH_DEF;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    // one long receiver hold-off, long enough to back the engine up into its input
    localparam int unsigned      LONG_HOLD_CYCLES = 150;

    // One predicted response, in port order.
    typedef struct {
        status_t          code;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] cnt;
        logic             is_last;
    } list_rsp_t;

    // Shadow copy of the list. note_request applies an accepted request and queues the
    // responses it must cause; check_response pops the oldest one and compares it.
    class list_mirror;
        logic [VAL_W-1:0] entries [DEPTH];
        int unsigned      live_count;
        list_rsp_t        pending [$];
        int unsigned      failures;
        int unsigned      checked;
        int unsigned      peak_count;
        int unsigned      op_seen [4];
        int unsigned      status_seen [5];

        function new();
            live_count = 0;
            failures   = 0;
            checked    = 0;
            peak_count = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void queue_response(status_t code, int unsigned pos,
                                     logic [VAL_W-1:0] val, logic is_last);
            list_rsp_t r;
            r.code    = code;
            r.pos     = pos[POS_W-1:0];
            r.val     = val;
            r.cnt     = live_count[CNT_W-1:0];
            r.is_last = is_last;
            pending.push_back(r);
            status_seen[code]++;
        endfunction

        function void note_request(op_t kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] key);
            int last_hit;
            op_seen[kind]++;
            if (kind == OP_INSERT) begin
                if (live_count >= DEPTH)
                    queue_response(STAT_FULL, 0, '0, 1'b1);
                else if (pos > live_count)
                    queue_response(STAT_RANGE, 0, '0, 1'b1);
                else
                begin
                    for (int i = live_count; i > pos; i--)
                        entries[i] = entries[i-1];
                    entries[pos] = key;
                    live_count++;
                    if (live_count > peak_count)
                        peak_count = live_count;
                    queue_response(STAT_OK, pos, '0, 1'b1);
                end
            end
            else if (live_count == 0)
                queue_response(STAT_EMPTY, 0, '0, 1'b1);
            else if (kind == OP_SEARCH)
            begin
                // every live entry is compared, the final one included
                last_hit = -1;
                for (int i = 0; i < live_count; i++)
                    if (entries[i] == key)
                        last_hit = i;
                if (last_hit < 0)
                    queue_response(STAT_NOT_FOUND, 0, '0, 1'b1);
                else
                    for (int i = 0; i <= last_hit; i++)
                        if (entries[i] == key)
                            queue_response(STAT_OK, i, entries[i], i == last_hit);
            end
            else if (pos >= live_count)
                queue_response(STAT_RANGE, 0, '0, 1'b1);
            else if (kind == OP_READ)
                queue_response(STAT_OK, pos, entries[pos], 1'b1);
            else
            begin
                for (int i = pos; i + 1 < live_count; i++)
                    entries[i] = entries[i+1];
                live_count--;
                queue_response(STAT_OK, pos, '0, 1'b1);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_response(logic [STAT_W-1:0] code, logic [POS_W-1:0] pos,
                                     logic [VAL_W-1:0] val, logic [CNT_W-1:0] cnt,
                                     logic is_last);
            list_rsp_t want;
            checked++;
            if (pending.size() == 0)
            begin
                failures++;
                $display("%0t: response with none outstanding, expected none actual status %0d",
                         $time, code);
                return;
            end
            want = pending.pop_front();
            check_field("status", want.code, code);
            check_field("found_position", want.pos, pos);
            check_field("read_value", want.val, val);
            check_field("entry_count", want.cnt, cnt);
            check_field("last", want.is_last, is_last);
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_stall;
    logic [OP_W-1:0]   op          = OP_INSERT;
    logic [POS_W-1:0]  position    = '0;
    logic [VAL_W-1:0]  value       = '0;
    logic              rsp_valid;
    logic              rsp_stall   = 1'b0;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
    logic [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]  entry_count;
    logic              last;

    // Idling controls shared by the sender, the receiver and the sequence.
    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    bit long_hold  = 1'b0;

    list_mirror mirror;

    positional_list_engine_top #(.DEPTH(DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .op             (op),
        .position       (position),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .found_position (found_position),
        .read_value     (read_value),
        .entry_count    (entry_count),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Values: half from a small pool so searches hit several positions, plus the extremes
    // and fully random words so every bit of the field toggles.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1:    return VAL_W'($urandom_range(0, 5));
            2:       return ($urandom_range(0, 1) == 0) ? '0 : VAL_MAX;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Positions: mostly legal for the current list, one in eight anywhere in 0..63.
    function automatic int unsigned pick_position(op_t kind);
        int unsigned n;
        n = mirror.live_count;
        if ($urandom_range(0, 7) == 0 || (kind != OP_INSERT && n == 0))
            return $urandom_range(0, 63);
        if (kind == OP_INSERT)
            return (n > 63) ? 63 : $urandom_range(0, n);
        return $urandom_range(0, n - 1);
    endfunction

    // Search keys: usually a value that is in the list, so matches are common.
    function automatic logic [VAL_W-1:0] pick_key();
        if (mirror.live_count > 0 && $urandom_range(0, 9) < 6)
            return mirror.entries[$urandom_range(0, mirror.live_count - 1)];
        return pick_value();
    endfunction

    // Offer one request after a random gap and hold it until the engine takes it.
    // Entered and left at a rising edge; valid stays high across back-to-back requests.
    task automatic send_request(op_t kind, int unsigned pos, logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= kind;
        position  <= pos[POS_W-1:0];
        value     <= val;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        mirror.note_request(kind, pos[POS_W-1:0], val);
    endtask

    // A stretch of random requests; op weights in percent, search takes the rest.
    task automatic run_phase(int unsigned n, int unsigned w_ins, int unsigned w_rem,
                             int unsigned w_read);
        int unsigned      r;
        op_t              kind;
        int unsigned      pos;
        logic [VAL_W-1:0] val;
        repeat (n)
        begin
            r    = $urandom_range(0, 99);
            kind = (r < w_ins) ? OP_INSERT :
                   (r < w_ins + w_rem) ? OP_REMOVE :
                   (r < w_ins + w_rem + w_read) ? OP_READ : OP_SEARCH;
            pos  = pick_position(kind);
            val  = (kind == OP_SEARCH) ? pick_key() : pick_value();
            send_request(kind, pos, val);
        end
    endtask

    // Response side: random stall before each response, or the one long hold-off when
    // the sequence asks for it. A response is taken at an edge with valid high and
    // stall low, both seen as they were just before the edge.
    initial
    begin : response_sink
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold)
            begin
                hold      = LONG_HOLD_CYCLES;
                long_hold = 1'b0;
            end
            else
                hold = rx_no_idle ? 0 : $urandom_range(0, 4);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            mirror.check_response(status, found_position, read_value, entry_count, last);
        end
    end

    // Main sequence.
    initial
    begin : sequencer
        mirror = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors on the empty list, inserts at front, middle and end,
        // searches with several matches (one on the final entry), none, and the extremes.
        send_request(OP_REMOVE, 0, '0);
        send_request(OP_READ, 63, VAL_MAX);
        send_request(OP_SEARCH, 0, '0);
        send_request(OP_INSERT, 1, 7);          // past the end of an empty list
        send_request(OP_INSERT, 0, VAL_MAX);
        send_request(OP_INSERT, 1, '0);
        send_request(OP_INSERT, 0, 5);
        send_request(OP_INSERT, 2, 5);
        send_request(OP_INSERT, 4, 5);          // list is now 5, max, 5, 0, 5
        send_request(OP_SEARCH, 0, 5);          // three hits, the last at the final entry
        send_request(OP_SEARCH, 63, '0);
        send_request(OP_SEARCH, 0, 9);          // no hit
        send_request(OP_SEARCH, 0, VAL_MAX);
        send_request(OP_READ, 4, '0);
        send_request(OP_READ, 0, '0);
        send_request(OP_READ, 5, '0);           // one past the end
        send_request(OP_READ, 63, '0);
        send_request(OP_REMOVE, 5, '0);
        send_request(OP_REMOVE, 63, VAL_MAX);
        send_request(OP_INSERT, 63, VAL_MAX);
        send_request(OP_REMOVE, 4, '0);         // end
        send_request(OP_REMOVE, 0, '0);         // front
        send_request(OP_REMOVE, 1, '0);         // middle

        // Insert-heavy: fills the list to DEPTH and keeps pushing into a full list,
        // with long searches over small-pool values.
        run_phase(120, 85, 5, 5);

        // Remove-heavy, with no idling on either side.
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        run_phase(90, 10, 75, 5);
        rx_no_idle = 1'b0;

        // Back-pressure: the receiver holds off for a long stretch while requests keep
        // coming with no gaps, so the output register fills and the input stalls.
        long_hold = 1'b1;
        run_phase(30, 40, 10, 10);
        tx_no_idle = 1'b0;

        // Mixed traffic.
        run_phase(110, 35, 20, 20);
        req_valid <= 1'b0;

        while (mirror.pending.size() != 0) @(posedge clk);
        // Keep running past a full-list search to catch stray responses.
        repeat (DEPTH + 16) @(posedge clk);

        $display("Ran %0d inserts, %0d removes, %0d reads, %0d searches; %0d responses, %0s%0d",
                 mirror.op_seen[OP_INSERT], mirror.op_seen[OP_REMOVE],
                 mirror.op_seen[OP_READ], mirror.op_seen[OP_SEARCH], mirror.checked,
                 "peak list length ", mirror.peak_count);
        $display("Statuses: ok %0d, full %0d, empty %0d, out of range %0d, not found %0d",
                 mirror.status_seen[STAT_OK], mirror.status_seen[STAT_FULL],
                 mirror.status_seen[STAT_EMPTY], mirror.status_seen[STAT_RANGE],
                 mirror.status_seen[STAT_NOT_FOUND]);
        if (mirror.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run (every search at 64 hits, each response
    // stalled for the longest random hold-off, every request after the longest random gap).
    initial
    begin : watchdog
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ positional_list_engine_top.f @@
design/ple_pkg.sv
design/ple_ram.sv
design/positional_list_engine_top.sv
sim/positional_list_engine_top_tb.sv
